>>> sv/wlsl_pkg.sv
`timescale 1ns / 1ps

package wlsl_pkg;

  // Coefficient refresh period in frames and the width of its counter.
  localparam int COEF_UPDATE_INTERVAL = 30;
  localparam int UPD_CNT_W = 10;

  // Lookup table geometry.
  localparam int TAB_BITS = 10;
  localparam int TAB_N = 1 << TAB_BITS;
  localparam int TAB_Q = TAB_N / 4;

  // Fixed-point constants.
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  // Series denominators: (2n)(2n+1) for the sine terms and n for the exponential terms.
  localparam longint SINE_DEN [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
                                      64'sd156, 64'sd210};
  localparam longint EXP_DEN [16] = '{64'sd1, 64'sd2, 64'sd3, 64'sd4, 64'sd5, 64'sd6,
                                      64'sd7, 64'sd8, 64'sd9, 64'sd10, 64'sd11, 64'sd12,
                                      64'sd13, 64'sd14, 64'sd15, 64'sd16};

  // Divider geometry.
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 38;
  localparam int DIV_CNT_W = 6;

  // Filter taps, in the order in which they are multiplied.
  localparam logic [2:0] TAP_B0_X = 3'd0;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_LAST = 3'd4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LFO_STEP,
    REG_START_PHASE,
    REG_SWEEP_DEPTH,
    REG_FREQ_OFFSET,
    REG_RESONANCE
  } reg_idx_t;

  typedef enum logic {
    TAB_SINE,
    TAB_EXP
  } tab_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_C,
    ST_LFO_MUL,
    ST_F_MUL,
    ST_RD_E,
    ST_RD_S,
    ST_RD_CS,
    ST_ALPHA,
    ST_WAIT_ALPHA,
    ST_B1,
    ST_WAIT_B1,
    ST_A1,
    ST_WAIT_A1,
    ST_A2,
    ST_WAIT_A2,
    ST_STORE_A2,
    ST_FMAC,
    ST_FLAST,
    ST_FSTORE,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_RD_C,
    OP_LFO_MUL,
    OP_F_MUL,
    OP_RD_E,
    OP_RD_S,
    OP_RD_CS,
    OP_ALPHA,
    OP_B1,
    OP_A1,
    OP_A2,
    OP_STORE_A2,
    OP_FMAC,
    OP_FLAST,
    OP_FSTORE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       ch;
    logic [2:0] tap;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef logic signed [31:0] sine_tab_t [TAB_N];
  typedef logic signed [31:0] exp_tab_t [TAB_N + 1];

  // sin(2*pi*k/N) over the first quarter turn, Q2.30, Taylor series.
  function automatic longint sine_quarter(input longint k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x = (TWO_PI_Q30 * k) >>> TAB_BITS;
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) / ONE_Q30;
      term = -term / SINE_DEN[n - 1];
      sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic longint sine_entry(input longint k);
    longint q;
    longint h;
    longint kk;
    q = TAB_N / 4;
    h = TAB_N / 2;
    kk = k;
    if (kk <= q) return sine_quarter(kk);
    if (kk <= h) return sine_quarter(h - kk);
    kk = kk - h;
    if (kk <= q) return -sine_quarter(kk);
    return -sine_quarter(h - kk);
  endfunction

  // exp(6*(k/N - 1)), Q2.30: exp(-z) with z an eighth of the span, then squared three times.
  function automatic longint exp_entry(input longint k);
    longint z;
    longint term;
    longint sum;
    z = ((6 * ONE_Q30) * (TAB_N - k)) >>> (TAB_BITS + 3);
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int n = 1; n <= 16; n++) begin
      term = -((term * z) / ONE_Q30) / EXP_DEN[n - 1];
      sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    for (int i = 0; i < 3; i++) begin
      sum = (sum * sum) / ONE_Q30;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int k = 0; k < TAB_N; k++) begin
      t[k] = 32'(sine_entry(longint'(k)));
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t t;
    for (int k = 0; k <= TAB_N; k++) begin
      t[k] = 32'(exp_entry(longint'(k)));
    end
    return t;
  endfunction

endpackage

>>> sv/wlsl_in_if.sv
`timescale 1ns / 1ps

// Input frame channel: one stereo word per handshake.
interface wlsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

>>> sv/wlsl_out_if.sv
`timescale 1ns / 1ps

// Output frame channel: one filtered stereo word per handshake.
interface wlsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

>>> sv/wlsl_rom.sv
`timescale 1ns / 1ps

module wlsl_rom
  import wlsl_pkg::*;
(
  input  logic                clk,
  input  tab_sel_t            sel,
  input  logic [TAB_BITS:0]   addr,
  output logic signed [31:0]  data
);

  localparam sine_tab_t SINE_ROM = build_sine();
  localparam exp_tab_t EXP_ROM = build_exp();

  // Registered read of either table; the sine table wraps on the low bits.
  always_ff @(posedge clk) begin
    unique case (sel)
      TAB_SINE: data <= SINE_ROM[addr[TAB_BITS-1:0]];
      TAB_EXP:  data <= EXP_ROM[addr];
      default:  data <= SINE_ROM[addr[TAB_BITS-1:0]];
    endcase
  end

endmodule

>>> sv/wlsl_div.sv
`timescale 1ns / 1ps

module wlsl_div
  import wlsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // One restoring step: shift in the next numerator bit and try the subtraction.
  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign ge = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  // Quotient bits shift in where the numerator shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], ge};
      rem <= ge ? DIV_DEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_DEN_W-1:0];
    end
  end

endmodule

>>> sv/wlsl_ctrl.sv
`timescale 1ns / 1ps

module wlsl_ctrl
  import wlsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [UPD_CNT_W-1:0] CNT_LAST = UPD_CNT_W'(COEF_UPDATE_INTERVAL - 1);

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [UPD_CNT_W-1:0] upd_cnt;
  logic [UPD_CNT_W-1:0] upd_cnt_next;
  logic [2:0]           tap;
  logic [2:0]           tap_next;
  logic                 ch;
  logic                 ch_next;

  // State, frame counter and tap sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      upd_cnt <= '0;
      tap     <= '0;
      ch      <= 1'b0;
    end else begin
      state   <= state_next;
      upd_cnt <= upd_cnt_next;
      tap     <= tap_next;
      ch      <= ch_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    upd_cnt_next = upd_cnt;
    tap_next     = tap;
    ch_next      = ch;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.ch       = ch;
    cmd.tap      = tap;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op       = OP_TAKE;
          tap_next     = TAP_B0_X;
          ch_next      = 1'b0;
          upd_cnt_next = (upd_cnt == CNT_LAST) ? '0 : upd_cnt + 1'b1;
          state_next   = (upd_cnt == '0) ? ST_RD_C : ST_FMAC;
        end
      end
      ST_RD_C: begin
        cmd.op     = OP_RD_C;
        state_next = ST_LFO_MUL;
      end
      ST_LFO_MUL: begin
        cmd.op     = OP_LFO_MUL;
        state_next = ST_F_MUL;
      end
      ST_F_MUL: begin
        cmd.op     = OP_F_MUL;
        state_next = ST_RD_E;
      end
      ST_RD_E: begin
        cmd.op     = OP_RD_E;
        state_next = ST_RD_S;
      end
      ST_RD_S: begin
        cmd.op     = OP_RD_S;
        state_next = ST_RD_CS;
      end
      ST_RD_CS: begin
        cmd.op     = OP_RD_CS;
        state_next = ST_ALPHA;
      end
      ST_ALPHA: begin
        cmd.op     = OP_ALPHA;
        state_next = ST_WAIT_ALPHA;
      end
      ST_WAIT_ALPHA: if (status.div_done) state_next = ST_B1;
      ST_B1: begin
        cmd.op     = OP_B1;
        state_next = ST_WAIT_B1;
      end
      ST_WAIT_B1: if (status.div_done) state_next = ST_A1;
      ST_A1: begin
        cmd.op     = OP_A1;
        state_next = ST_WAIT_A1;
      end
      ST_WAIT_A1: if (status.div_done) state_next = ST_A2;
      ST_A2: begin
        cmd.op     = OP_A2;
        state_next = ST_WAIT_A2;
      end
      ST_WAIT_A2: if (status.div_done) state_next = ST_STORE_A2;
      ST_STORE_A2: begin
        cmd.op     = OP_STORE_A2;
        state_next = ST_FMAC;
      end
      ST_FMAC: begin
        cmd.op = OP_FMAC;
        if (tap == TAP_LAST) begin
          state_next = ST_FLAST;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      ST_FLAST: begin
        cmd.op     = OP_FLAST;
        state_next = ST_FSTORE;
      end
      ST_FSTORE: begin
        cmd.op = OP_FSTORE;
        if (!ch) begin
          ch_next    = 1'b1;
          tap_next   = TAP_B0_X;
          state_next = ST_FMAC;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> sv/wlsl_dp.sv
`timescale 1ns / 1ps

module wlsl_dp
  import wlsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic [31:0]        lfo_step,
  input  logic [16:0]        sweep_depth,
  input  logic [16:0]        freq_offset,
  input  logic [12:0]        resonance,
  input  logic               phase_load,
  input  logic [15:0]        start_phase,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out
);

  localparam logic signed [32:0] ONE33 = 33'sd1073741824;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DIV_NUM_W-1:0] NUM_2_61 = DIV_NUM_W'(1) << 61;
  localparam logic [TAB_BITS-1:0] QTR = TAB_BITS'(TAB_Q);

  // Sweep state and intermediate registers.
  logic [31:0]              phase;
  logic signed [63:0]       prod;
  logic [2:0]               prod_tap;
  logic [TAB_BITS:0]        oi;
  logic [30:0]              sn;
  logic signed [31:0]       cs;
  logic [DIV_DEN_W-1:0]     a0;
  logic signed [31:0]       coef_b0, coef_b1, coef_a1, coef_a2;
  logic signed [15:0]       x_l, x_r;
  logic signed [15:0]       xh1 [2];
  logic signed [15:0]       xh2 [2];
  logic signed [31:0]       yh1 [2];
  logic signed [31:0]       yh2 [2];
  logic signed [51:0]       acc;
  logic signed [15:0]       res_l, res_r;

  // Shared units.
  tab_sel_t                 rom_sel;
  logic [TAB_BITS:0]        rom_addr;
  logic signed [31:0]       rom_data;
  logic                     div_start;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_q;
  logic signed [33:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [66:0]       mul_p;

  // Derived values.
  logic signed [32:0]       lfo_sum;
  logic [16:0]              lfo16;
  logic [16:0]              off_inv;
  logic [17:0]              f_sum;
  logic [16:0]              f_cl;
  logic [TAB_BITS:0]        ek;
  logic [TAB_BITS:0]        oi_now;
  logic [30:0]              sn_now;
  logic signed [32:0]       omc;
  logic [31:0]              cs_abs;
  logic [DIV_DEN_W-1:0]     a0_now;
  logic [31:0]              q_sat;
  logic signed [32:0]       q_neg;
  logic signed [15:0]       x_cur;
  logic signed [51:0]       term;
  logic signed [51:0]       acc_sum;
  logic signed [36:0]       ys;
  logic signed [31:0]       y32;
  logic signed [17:0]       yo;
  logic signed [15:0]       o16;

  wlsl_rom u_rom (
    .clk  (clk),
    .sel  (rom_sel),
    .addr (rom_addr),
    .data (rom_data)
  );

  wlsl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign mul_p = mul_a * mul_b;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  // LFO level and swept frequency.
  assign lfo_sum = ONE33 + 33'(rom_data);
  assign lfo16   = lfo_sum[31:15];
  assign off_inv = 17'(17'd65536 - freq_offset);
  assign f_sum   = {1'b0, prod[48:32]} + {1'b0, freq_offset};
  assign f_cl    = (f_sum > 18'd65536) ? 17'd65536 : f_sum[16:0];
  assign ek      = f_cl[16 -: TAB_BITS + 1];
  assign oi_now  = rom_data[31 -: TAB_BITS + 1];
  assign sn_now  = rom_data[31] ? '0 : rom_data[30:0];

  // Coefficient terms.
  assign omc    = ONE33 - 33'(cs);
  assign cs_abs = cs[31] ? 32'(-cs) : 32'(cs);
  assign a0_now = DIV_DEN_W'(ONE_Q30) + div_q[DIV_DEN_W-1:0];
  assign q_sat  = (div_q > DIV_NUM_W'(POS_MAX)) ? POS_MAX : div_q[31:0];
  assign q_neg  = -$signed({1'b0, div_q[31:0]});

  // Filter accumulation: feedback products are floored by 15 bits and subtracted.
  assign x_cur   = cmd.ch ? x_r : x_l;
  assign term    = (prod_tap < TAP_A1) ? prod[51:0] : 52'(prod >>> 15);
  assign acc_sum = (prod_tap < TAP_A1) ? acc + term : acc - term;

  // Output scaling with saturation.
  assign ys  = 37'(acc >>> 15);
  assign y32 = (ys > 37'sd2147483647) ? 32'sh7FFF_FFFF :
               (ys < -37'sd2147483648) ? 32'sh8000_0000 : ys[31:0];
  assign yo  = 18'((33'(y32) + 33'sd16384) >>> 15);
  assign o16 = (yo > 18'sd32767) ? 16'sh7FFF :
               (yo < -18'sd32768) ? 16'sh8000 : yo[15:0];

  // Operand selection for the table, the multiplier and the divider.
  always_comb begin
    rom_sel   = TAB_SINE;
    rom_addr  = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      OP_RD_C: rom_addr = {1'b0, phase[31 -: TAB_BITS] + QTR};
      OP_LFO_MUL: begin
        mul_a = 34'(lfo16);
        mul_b = 33'(sweep_depth);
      end
      OP_F_MUL: begin
        mul_a = prod[33:0];
        mul_b = 33'(off_inv);
      end
      OP_RD_E: begin
        rom_sel  = TAB_EXP;
        rom_addr = ek;
      end
      OP_RD_S:  rom_addr = {1'b0, oi_now[TAB_BITS-1:0]};
      OP_RD_CS: rom_addr = {1'b0, oi[TAB_BITS-1:0] + QTR};
      OP_ALPHA: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({sn, 7'b0});
        div_den   = DIV_DEN_W'(resonance);
      end
      OP_B1: begin
        div_start = 1'b1;
        div_num   = {omc[31:0], 30'b0};
        div_den   = a0_now;
      end
      OP_A1: begin
        div_start = 1'b1;
        div_num   = {cs_abs[30:0], 31'b0};
        div_den   = a0;
      end
      OP_A2: begin
        div_start = 1'b1;
        div_num   = NUM_2_61;
        div_den   = a0;
      end
      OP_FMAC: begin
        unique case (cmd.tap)
          3'd0: begin
            mul_a = 34'(coef_b0);
            mul_b = 33'(x_cur);
          end
          3'd1: begin
            mul_a = 34'(coef_b1);
            mul_b = 33'(xh1[cmd.ch]);
          end
          3'd2: begin
            mul_a = 34'(coef_b0);
            mul_b = 33'(xh2[cmd.ch]);
          end
          3'd3: begin
            mul_a = 34'(coef_a1);
            mul_b = 33'(yh1[cmd.ch]);
          end
          3'd4: begin
            mul_a = 34'(coef_a2);
            mul_b = 33'(yh2[cmd.ch]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Phase, coefficients, filter history and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      coef_b0   <= '0;
      coef_b1   <= '0;
      coef_a1   <= '0;
      coef_a2   <= '0;
      xh1[0]    <= '0;
      xh1[1]    <= '0;
      xh2[0]    <= '0;
      xh2[1]    <= '0;
      yh1[0]    <= '0;
      yh1[1]    <= '0;
      yh2[0]    <= '0;
      yh2[1]    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (phase_load) begin
        phase <= {start_phase, 16'b0};
      end else if (cmd.op == OP_TAKE) begin
        phase <= phase + lfo_step;
      end
      if (cmd.op == OP_A1) begin
        coef_b0 <= 32'(div_q[DIV_NUM_W-1:1]);
        coef_b1 <= q_sat;
      end
      if (cmd.op == OP_A2) begin
        coef_a1 <= cs[31] ? q_sat : q_neg[31:0];
      end
      if (cmd.op == OP_STORE_A2) begin
        coef_a2 <= 32'(33'(div_q[32:0]) - 33'(ONE_Q30));
      end
      if (cmd.op == OP_FSTORE) begin
        xh2[cmd.ch] <= xh1[cmd.ch];
        xh1[cmd.ch] <= x_cur;
        yh2[cmd.ch] <= yh1[cmd.ch];
        yh1[cmd.ch] <= y32;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE: begin
        x_l <= left_sample;
        x_r <= right_sample;
      end
      OP_LFO_MUL, OP_F_MUL: prod <= mul_p[63:0];
      OP_RD_S:  oi <= oi_now;
      OP_RD_CS: sn <= sn_now;
      OP_ALPHA: cs <= rom_data;
      OP_B1:    a0 <= a0_now;
      OP_FMAC: begin
        prod     <= mul_p[63:0];
        prod_tap <= cmd.tap;
        acc      <= (cmd.tap == TAP_B0_X) ? '0 : acc_sum;
      end
      OP_FLAST: acc <= acc_sum;
      OP_FSTORE: begin
        if (cmd.ch) res_r <= o16;
        else res_l <= o16;
      end
      OP_EMIT: begin
        left_out  <= res_l;
        right_out <= res_r;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/wah_lfo_swept_lowpass_core.sv
`timescale 1ns / 1ps

// Stereo wah: a cosine LFO sweeps the cutoff of a lowpass biquad shared by both channels.
// Frames enter on in_ch and leave on out_ch, one stereo word per valid/ready handshake.
// The block works on one frame at a time and takes the next frame once the current one
// has been placed in the output register, even if that word still waits to be taken.
// A frame without a coefficient refresh runs the five taps of each channel in turn through
// the one shared 34x33 multiplier.
// On the first frame and then every 30th frame the coefficients are recomputed before
// filtering, using four bit-serial divisions of a 62-bit numerator.
// When the receiver stalls, the finished word holds on out_ch and the next frame waits
// in the output stage step until the output register frees.
// Reset (rst, synchronous) restores the control and configuration registers to defaults,
// clears filter history and coefficients and sets the LFO phase to start_phase. Registers
// sit at APB byte addresses 0, 4, 8, 12 and 16; writing start_phase reloads the LFO phase.
// The user must write them only while the block is idle; the block does not enforce it.
module wah_lfo_swept_lowpass_core
  import wlsl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  wlsl_in_if.sink       in_ch,
  wlsl_out_if.source    out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [31:0] lfo_step;
  logic [15:0] start_phase;
  logic [16:0] sweep_depth;
  logic [16:0] freq_offset;
  logic [12:0] resonance;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        phase_load;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = reg_idx_t'(paddr[4:2]);
  assign phase_load = cfg_wr && (cfg_idx == REG_START_PHASE);

  // Register writes, with depth and offset limited to one and zero resonance taken as 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_step    <= 32'd134218;
      start_phase <= '0;
      sweep_depth <= 17'd45875;
      freq_offset <= 17'd19661;
      resonance   <= 13'd640;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LFO_STEP:    lfo_step <= pwdata;
        REG_START_PHASE: start_phase <= pwdata[15:0];
        REG_SWEEP_DEPTH:
          sweep_depth <= (pwdata[16:0] > 17'd65536) ? 17'd65536 : pwdata[16:0];
        REG_FREQ_OFFSET:
          freq_offset <= (pwdata[16:0] > 17'd65536) ? 17'd65536 : pwdata[16:0];
        REG_RESONANCE:
          resonance <= (pwdata[12:0] == '0) ? 13'd1 : pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      REG_LFO_STEP:    prdata = lfo_step;
      REG_START_PHASE: prdata = 32'(start_phase);
      REG_SWEEP_DEPTH: prdata = 32'(sweep_depth);
      REG_FREQ_OFFSET: prdata = 32'(freq_offset);
      REG_RESONANCE:   prdata = 32'(resonance);
      default:         prdata = '0;
    endcase
  end

  wlsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wlsl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .lfo_step     (lfo_step),
    .sweep_depth  (sweep_depth),
    .freq_offset  (freq_offset),
    .resonance    (resonance),
    .phase_load   (phase_load),
    .start_phase  (pwdata[15:0]),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .left_out     (out_ch.left_out),
    .right_out    (out_ch.right_out)
  );

endmodule
